FILE: sv/jbt_pkg.sv
// jbt_pkg: types, codes and helper functions shared by the JSON byte tokenizer.
// No dependencies; imported by jbt_lexer, jbt_result_fifo and json_byte_tokenizer_unit.
`default_nettype none

package jbt_pkg;

  // Sizing
  localparam int MAX_STRING_LEN = 4095;
  localparam int MAX_DIGITS     = 18;
  localparam int STR_LEN_W      = $clog2(MAX_STRING_LEN + 1);
  localparam int DIGIT_CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int DIGITS_W       = 60;
  localparam int EXP_W          = 7;
  localparam int TOKEN_CNT_W    = 16;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [TOKEN_CNT_W-1:0] TOKEN_LIMIT_RST = {TOKEN_CNT_W{1'b1}};
  localparam logic signed [EXP_W-1:0] EXP_MAX = 7'sd63;

  // Token kinds
  localparam logic [3:0] KIND_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] KIND_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] KIND_ARR_OPEN  = 4'd2;
  localparam logic [3:0] KIND_ARR_CLOSE = 4'd3;
  localparam logic [3:0] KIND_COLON     = 4'd4;
  localparam logic [3:0] KIND_COMMA     = 4'd5;
  localparam logic [3:0] KIND_STR_BYTE  = 4'd6;
  localparam logic [3:0] KIND_STR_END   = 4'd7;
  localparam logic [3:0] KIND_BOOL      = 4'd8;
  localparam logic [3:0] KIND_NULL      = 4'd9;
  localparam logic [3:0] KIND_NUMBER    = 4'd10;

  // Characters
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_POINT     = 8'h2E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_U     = 8'h75;
  localparam logic [7:0] CH_LOW_E     = 8'h65;
  localparam logic [7:0] CH_LOW_A     = 8'h61;
  localparam logic [7:0] CH_LOW_L     = 8'h6C;
  localparam logic [7:0] CH_LOW_S     = 8'h73;

  // Literal selectors
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_LITERAL,
    MODE_NUMBER
  } lex_mode_t;

  // One result transaction
  typedef struct packed {
    logic [3:0]              token_kind;
    logic [7:0]              string_char;
    logic                    bool_value;
    logic                    is_negative;
    logic [DIGITS_W-1:0]     digits_value;
    logic signed [EXP_W-1:0] decimal_exponent;
    logic                    run_last;
  } res_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_pair_t;

  function automatic res_t make_res(input logic [3:0] kind, input logic [7:0] ch,
                                    input logic b, input logic neg,
                                    input logic [DIGITS_W-1:0] digits,
                                    input logic signed [EXP_W-1:0] expo);
    res_t r;
    r.token_kind       = kind;
    r.string_char      = ch;
    r.bool_value       = b;
    r.is_negative      = neg;
    r.digits_value     = digits;
    r.decimal_exponent = expo;
    r.run_last         = 1'b0;
    return r;
  endfunction

  // Append a result; a full pair drops further ones
  function automatic res_pair_t push_res(input res_pair_t pair, input res_t r);
    res_pair_t p;
    p = pair;
    case (pair.count)
      2'd0: begin
        p.first = r;
        p.count = 2'd1;
      end
      2'd1: begin
        p.second = r;
        p.count  = 2'd2;
      end
      default: p = pair;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: sv/jbt_lexer.sv
// jbt_lexer: lexer state registers and the one-byte step that yields up to two results.
// Depends on jbt_pkg.
`default_nettype none

module jbt_lexer
  import jbt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [TOKEN_CNT_W-1:0] cfg_wr_data,
  input  wire logic                   in_fire,
  input  wire logic [7:0]             text_byte,
  input  wire logic                   doc_end,
  output res_pair_t                   push
);

  localparam logic [STR_LEN_W-1:0]   STR_LIMIT   = STR_LEN_W'(MAX_STRING_LEN);
  localparam logic [DIGIT_CNT_W-1:0] DIGIT_LIMIT = DIGIT_CNT_W'(MAX_DIGITS);

  lex_mode_t                   mode_r,        mode_nxt;
  logic [1:0]                  lit_which_r,   lit_which_nxt;
  logic [1:0]                  lit_pos_r,     lit_pos_nxt;
  logic                        lit_miss_r,    lit_miss_nxt;
  logic                        prev_bs_r,     prev_bs_nxt;
  logic [STR_LEN_W-1:0]        str_len_r,     str_len_nxt;
  logic [DIGITS_W-1:0]         digits_r,      digits_nxt;
  logic signed [EXP_W-1:0]     exp_r,         exp_nxt;
  logic                        sign_r,        sign_nxt;
  logic [1:0]                  point_cnt_r,   point_cnt_nxt;
  logic [DIGIT_CNT_W-1:0]      digit_cnt_r,   digit_cnt_nxt;
  logic [TOKEN_CNT_W-1:0]      tokens_r,      tokens_nxt;
  logic [TOKEN_CNT_W-1:0]      token_limit_r;

  res_pair_t   pair;
  logic        do_dispatch;
  logic        do_add;
  logic        struct_hit;
  logic [3:0]  struct_kind;
  logic [2:0]  lit_pos_inc;
  logic [3:0]  digit_val;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Expected byte of a literal after its first letter
  function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (which)
      LIT_TRUE: begin
        case (pos)
          2'd0:    ch = CH_LOW_R;
          2'd1:    ch = CH_LOW_U;
          2'd2:    ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          2'd0:    ch = CH_LOW_A;
          2'd1:    ch = CH_LOW_L;
          2'd2:    ch = CH_LOW_S;
          default: ch = CH_LOW_E;
        endcase
      end
      default: begin
        case (pos)
          2'd0:    ch = CH_LOW_U;
          2'd1:    ch = CH_LOW_L;
          2'd2:    ch = CH_LOW_L;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] which);
    logic [2:0] n;
    case (which)
      LIT_FALSE: n = 3'd4;
      default:   n = 3'd3;
    endcase
    return n;
  endfunction

  // Step one byte: mode handling, idle dispatch, digit accumulation, flush
  always_comb begin
    mode_nxt      = mode_r;
    lit_which_nxt = lit_which_r;
    lit_pos_nxt   = lit_pos_r;
    lit_miss_nxt  = lit_miss_r;
    prev_bs_nxt   = prev_bs_r;
    str_len_nxt   = str_len_r;
    digits_nxt    = digits_r;
    exp_nxt       = exp_r;
    sign_nxt      = sign_r;
    point_cnt_nxt = point_cnt_r;
    digit_cnt_nxt = digit_cnt_r;
    tokens_nxt    = tokens_r;
    pair          = '0;
    do_dispatch   = 1'b0;
    do_add        = 1'b0;
    struct_hit    = 1'b0;
    struct_kind   = KIND_OBJ_OPEN;
    lit_pos_inc   = {1'b0, lit_pos_r} + 3'd1;
    digit_val     = text_byte[3:0];

    case (mode_r)
      MODE_STRING: begin
        if (text_byte == CH_QUOTE && !prev_bs_r) begin
          pair     = push_res(pair, make_res(KIND_STR_END, 8'h00, 1'b0, 1'b0, '0, '0));
          mode_nxt = MODE_IDLE;
        end else begin
          pair        = push_res(pair, make_res(KIND_STR_BYTE, text_byte, 1'b0, 1'b0,
                                                '0, '0));
          prev_bs_nxt = (text_byte == CH_BACKSLASH);
          str_len_nxt = str_len_r + 1'b1;
          // close at the length limit
          if (str_len_nxt >= STR_LIMIT) begin
            pair     = push_res(pair, make_res(KIND_STR_END, 8'h00, 1'b0, 1'b0, '0, '0));
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_LITERAL: begin
        if (text_byte == CH_NEWLINE) begin
          mode_nxt = MODE_IDLE;
        end else begin
          lit_miss_nxt = lit_miss_r | (text_byte != lit_char(lit_which_r, lit_pos_r));
          lit_pos_nxt  = lit_pos_inc[1:0];
          if (lit_pos_inc >= lit_len(lit_which_r)) begin
            mode_nxt = MODE_IDLE;
            if (!lit_miss_nxt) begin
              if (lit_which_r == LIT_NULL) begin
                pair = push_res(pair, make_res(KIND_NULL, 8'h00, 1'b0, 1'b0, '0, '0));
              end else begin
                pair = push_res(pair, make_res(KIND_BOOL, 8'h00,
                                               (lit_which_r == LIT_TRUE), 1'b0, '0, '0));
              end
              tokens_nxt = tokens_nxt + 1'b1;
            end
          end
        end
      end
      MODE_NUMBER: begin
        if (is_digit(text_byte) || text_byte == CH_POINT) begin
          do_add = 1'b1;
        end else begin
          // emit the number, then treat this byte as in idle
          pair        = push_res(pair, make_res(KIND_NUMBER, 8'h00, 1'b0, sign_r,
                                                digits_r, exp_r));
          tokens_nxt  = tokens_nxt + 1'b1;
          mode_nxt    = MODE_IDLE;
          do_dispatch = 1'b1;
        end
      end
      default: begin
        do_dispatch = 1'b1;
      end
    endcase

    // Idle dispatch, gated by the token limit
    if (do_dispatch && (tokens_nxt < token_limit_r)) begin
      case (text_byte)
        CH_LBRACE: begin
          struct_hit  = 1'b1;
          struct_kind = KIND_OBJ_OPEN;
        end
        CH_RBRACE: begin
          struct_hit  = 1'b1;
          struct_kind = KIND_OBJ_CLOSE;
        end
        CH_LBRACKET: begin
          struct_hit  = 1'b1;
          struct_kind = KIND_ARR_OPEN;
        end
        CH_RBRACKET: begin
          struct_hit  = 1'b1;
          struct_kind = KIND_ARR_CLOSE;
        end
        CH_COLON: begin
          struct_hit  = 1'b1;
          struct_kind = KIND_COLON;
        end
        CH_COMMA: begin
          struct_hit  = 1'b1;
          struct_kind = KIND_COMMA;
        end
        CH_QUOTE: begin
          mode_nxt    = MODE_STRING;
          str_len_nxt = '0;
          prev_bs_nxt = 1'b0;
          tokens_nxt  = tokens_nxt + 1'b1;
        end
        CH_LOW_T, CH_LOW_F, CH_LOW_N: begin
          mode_nxt      = MODE_LITERAL;
          lit_which_nxt = (text_byte == CH_LOW_T) ? LIT_TRUE :
                          (text_byte == CH_LOW_F) ? LIT_FALSE : LIT_NULL;
          lit_pos_nxt   = 2'd0;
          lit_miss_nxt  = 1'b0;
        end
        default: begin
          if (is_digit(text_byte) || text_byte == CH_MINUS) begin
            mode_nxt      = MODE_NUMBER;
            sign_nxt      = (text_byte == CH_MINUS);
            digits_nxt    = '0;
            exp_nxt       = '0;
            point_cnt_nxt = 2'd0;
            digit_cnt_nxt = '0;
            do_add        = (text_byte != CH_MINUS);
          end
        end
      endcase
      if (struct_hit) begin
        pair       = push_res(pair, make_res(struct_kind, 8'h00, 1'b0, 1'b0, '0, '0));
        tokens_nxt = tokens_nxt + 1'b1;
      end
    end

    // Accumulate a digit or point into the number
    if (do_add) begin
      if (text_byte == CH_POINT) begin
        if (point_cnt_nxt < 2'd2) begin
          point_cnt_nxt = point_cnt_nxt + 1'b1;
        end
      end else if (point_cnt_nxt == 2'd0) begin
        if (!(digit_cnt_nxt == '0 && digit_val == 4'd0)) begin
          if (digit_cnt_nxt < DIGIT_LIMIT) begin
            digits_nxt    = {digits_nxt[DIGITS_W-4:0], 3'b000}
                          + {digits_nxt[DIGITS_W-2:0], 1'b0}
                          + DIGITS_W'(digit_val);
            digit_cnt_nxt = digit_cnt_nxt + 1'b1;
          end else if (exp_nxt < EXP_MAX) begin
            exp_nxt = exp_nxt + 7'sd1;
          end
        end
      end else if (point_cnt_nxt == 2'd1) begin
        if (digit_cnt_nxt < DIGIT_LIMIT) begin
          digits_nxt    = {digits_nxt[DIGITS_W-4:0], 3'b000}
                        + {digits_nxt[DIGITS_W-2:0], 1'b0}
                        + DIGITS_W'(digit_val);
          digit_cnt_nxt = digit_cnt_nxt + 1'b1;
          exp_nxt       = exp_nxt - 7'sd1;
        end
      end
    end

    // Document end: flush an open token and clear
    if (doc_end) begin
      if (mode_nxt == MODE_NUMBER) begin
        pair = push_res(pair, make_res(KIND_NUMBER, 8'h00, 1'b0, sign_nxt,
                                       digits_nxt, exp_nxt));
      end else if (mode_nxt == MODE_STRING) begin
        pair = push_res(pair, make_res(KIND_STR_END, 8'h00, 1'b0, 1'b0, '0, '0));
      end
      mode_nxt      = MODE_IDLE;
      lit_which_nxt = 2'd0;
      lit_pos_nxt   = 2'd0;
      lit_miss_nxt  = 1'b0;
      prev_bs_nxt   = 1'b0;
      str_len_nxt   = '0;
      digits_nxt    = '0;
      exp_nxt       = '0;
      sign_nxt      = 1'b0;
      point_cnt_nxt = 2'd0;
      digit_cnt_nxt = '0;
      tokens_nxt    = '0;
    end

    // Mark the last result of this byte
    if (pair.count == 2'd2) begin
      pair.second.run_last = 1'b1;
    end else if (pair.count == 2'd1) begin
      pair.first.run_last = 1'b1;
    end
  end

  // Hand results to the queue only for an accepted transaction
  always_comb begin
    push       = pair;
    push.count = in_fire ? pair.count : 2'd0;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_limit_r <= TOKEN_LIMIT_RST;
      mode_r        <= MODE_IDLE;
      lit_which_r   <= 2'd0;
      lit_pos_r     <= 2'd0;
      lit_miss_r    <= 1'b0;
      prev_bs_r     <= 1'b0;
      str_len_r     <= '0;
      digits_r      <= '0;
      exp_r         <= '0;
      sign_r        <= 1'b0;
      point_cnt_r   <= 2'd0;
      digit_cnt_r   <= '0;
      tokens_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        token_limit_r <= cfg_wr_data;
      end
      if (in_fire) begin
        mode_r      <= mode_nxt;
        lit_which_r <= lit_which_nxt;
        lit_pos_r   <= lit_pos_nxt;
        lit_miss_r  <= lit_miss_nxt;
        prev_bs_r   <= prev_bs_nxt;
        str_len_r   <= str_len_nxt;
        digits_r    <= digits_nxt;
        exp_r       <= exp_nxt;
        sign_r      <= sign_nxt;
        point_cnt_r <= point_cnt_nxt;
        digit_cnt_r <= digit_cnt_nxt;
        tokens_r    <= tokens_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/jbt_result_fifo.sv
// jbt_result_fifo: small result queue taking up to two results per cycle, one out.
// Depends on jbt_pkg.
`default_nettype none

module jbt_result_fifo
  import jbt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_pair_t push,
  input  wire logic      out_ready,
  output logic           out_valid,
  output res_t           head,
  output logic           room_for_pair
);

  res_t                  slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r,  count_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_second;
  logic                  pop;

  assign out_valid     = (count_r != '0);
  assign head          = slot_r[rd_ptr_r];
  assign room_for_pair = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign pop           = out_valid && out_ready;
  assign wr_ptr_second = wr_ptr_r + 1'b1;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slot_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      slot_r[wr_ptr_second] <= push.second;
    end
  end

endmodule

`default_nettype wire

FILE: sv/json_byte_tokenizer_unit.sv
// json_byte_tokenizer_unit: top level of the byte-serial JSON tokenizer.
// Depends on jbt_pkg, jbt_lexer and jbt_result_fifo.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-----------------------------
//   input   | in_text_byte, in_doc_end       | in_valid / in_ready
//   result  | out_token_kind .. out_run_last | out_valid / out_ready
//   config  | cfg_wr_data (token_limit)      | cfg_wr_en, no wait
//
// One byte is accepted per cycle; its 0, 1 or 2 tokens are registered into a
// four-entry result queue and leave one per cycle while out_ready is high.
// in_ready stays high while the queue has room for two tokens; only a
// sustained run of two-token bytes or a stalled consumer lowers it.
// Synchronous active-low reset clears the lexer state and the queue and sets
// token_limit to 65535; no clearing pass follows.
`default_nettype none

module json_byte_tokenizer_unit
  import jbt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [TOKEN_CNT_W-1:0] cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_text_byte,
  input  wire logic                   in_doc_end,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3:0]                  out_token_kind,
  output logic [7:0]                  out_string_char,
  output logic                        out_bool_value,
  output logic                        out_is_negative,
  output logic [DIGITS_W-1:0]         out_digits_value,
  output logic signed [EXP_W-1:0]     out_decimal_exponent,
  output logic                        out_run_last
);

  res_pair_t push;
  res_t      head;
  logic      room_for_pair;
  logic      in_fire;

  // Accept a transaction while the queue can absorb a full pair
  assign in_ready = room_for_pair;
  assign in_fire  = in_valid && room_for_pair;

  jbt_lexer u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .text_byte   (in_text_byte),
    .doc_end     (in_doc_end),
    .push        (push)
  );

  jbt_result_fifo u_result_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .head          (head),
    .room_for_pair (room_for_pair)
  );

  // Drive result fields from the queue head
  assign out_token_kind       = head.token_kind;
  assign out_string_char      = head.string_char;
  assign out_bool_value       = head.bool_value;
  assign out_is_negative      = head.is_negative;
  assign out_digits_value     = head.digits_value;
  assign out_decimal_exponent = head.decimal_exponent;
  assign out_run_last         = head.run_last;

endmodule

`default_nettype wire
